// File: rtl/ncf_pkg.sv
// Package for the normalized 3x3 convolution filter: widths, types,
// register indexes and reset values shared by the lanes, the merge and the top.
// No dependencies.
`default_nettype none

package ncf_pkg;

   // Planes per pixel, and how many the result word can hold
   localparam int NCF_PLANES     = 4;
   localparam int NCF_MAX_PLANES = 4;

   localparam int PIX_W     = 8;
   localparam int TAPS      = 9;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = PIX_W + 1 + COEF_W;   // unsigned pixel times signed coefficient
   localparam int ROW_W     = PROD_W + 2;           // sum of three products
   localparam int SUM_W     = ROW_W + 2;            // sum of three rows
   localparam int SCALE_W   = 32;
   localparam int SCALED_W  = SUM_W + SCALE_W;
   localparam int FRAC_W    = 24;                   // Q8.8 times Q16.16
   localparam int WORD_W    = NCF_MAX_PLANES * PIX_W;
   localparam int ROW_COEF_W = 3 * COEF_W;

   // Lane stages (products, row sums, total, scaled) plus the output register
   localparam int PIPE_DEPTH = 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_COEF_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_TOP    = 3'd0,
      CSR_COEF_MIDDLE = 3'd1,
      CSR_COEF_BOTTOM = 3'd2,
      CSR_NORM_SCALE  = 3'd3,
      CSR_FOUR_PLANES = 3'd4
   } csr_idx_type;

   localparam logic [ROW_COEF_W-1:0] COEF_TOP_RESET    = 48'h0;
   localparam logic [ROW_COEF_W-1:0] COEF_MIDDLE_RESET = 48'h0000_0100_0000;
   localparam logic [ROW_COEF_W-1:0] COEF_BOTTOM_RESET = 48'h0;
   localparam logic [SCALE_W-1:0]    NORM_SCALE_RESET  = 32'h0001_0000;

   typedef logic [TAPS-1:0][WORD_W-1:0] window_type;   // tap 0 is top left
   typedef logic [TAPS-1:0][PIX_W-1:0]  pix_win_type;  // one plane of a window
   typedef logic [TAPS-1:0][COEF_W-1:0] kernel_type;   // tap 0 is top left
   typedef logic signed [SCALE_W-1:0]   scale_type;
   typedef logic signed [SCALED_W-1:0]  scaled_type;

endpackage

`default_nettype wire

// File: rtl/ncf_if.sv
// Channel interfaces of the filter: window requests, filtered pixel
// responses and register writes. Depends on ncf_pkg.
`default_nettype none

interface ncf_req_if import ncf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  win_top_left;
   logic [WORD_W-1:0]  win_top_mid;
   logic [WORD_W-1:0]  win_top_right;
   logic [WORD_W-1:0]  win_mid_left;
   logic [WORD_W-1:0]  win_center;
   logic [WORD_W-1:0]  win_mid_right;
   logic [WORD_W-1:0]  win_bottom_left;
   logic [WORD_W-1:0]  win_bottom_mid;
   logic [WORD_W-1:0]  win_bottom_right;

   modport source (
      output valid, win_top_left, win_top_mid, win_top_right, win_mid_left, win_center,
             win_mid_right, win_bottom_left, win_bottom_mid, win_bottom_right,
      input  ready
   );
   modport sink (
      input  valid, win_top_left, win_top_mid, win_top_right, win_mid_left, win_center,
             win_mid_right, win_bottom_left, win_bottom_mid, win_bottom_right,
      output ready
   );
endinterface

interface ncf_rsp_if import ncf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] filtered_pixel;

   modport source (output valid, filtered_pixel, input ready);
   modport sink (input valid, filtered_pixel, output ready);
endinterface

interface ncf_csr_if import ncf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/ncf_lane.sv
// One plane lane: nine products, row sums, window total and the scaled total,
// each stage registered. Depends on ncf_pkg.
`default_nettype none

module ncf_lane import ncf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        advance,
   input  wire pix_win_type pix,
   input  wire kernel_type  kernel,
   input  wire scale_type   scale,
   output scaled_type       scaled
);

   logic signed [PROD_W-1:0]   prod_ff [TAPS];
   logic signed [PROD_W-1:0]   prod_in [TAPS];
   logic signed [ROW_W-1:0]    row_ff [3];
   logic signed [ROW_W-1:0]    row_in [3];
   logic signed [SUM_W-1:0]    total_ff;
   logic signed [SUM_W-1:0]    total_in;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [SCALED_W-1:0] scaled_in;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         prod_in[i] = $signed({1'b0, pix[i]}) * $signed(kernel[i]);
      end
      for (int r = 0; r < 3; r++) begin
         row_in[r] = ROW_W'(prod_ff[3*r]) + ROW_W'(prod_ff[3*r+1]) + ROW_W'(prod_ff[3*r+2]);
      end
      total_in  = SUM_W'(row_ff[0]) + SUM_W'(row_ff[1]) + SUM_W'(row_ff[2]);
      scaled_in = total_ff * scale;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         row_ff    <= row_in;
         total_ff  <= total_in;
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

`default_nettype wire

// File: rtl/ncf_merge.sv
// Merge stage: clamps each lane's scaled total to a byte, masks the upper
// planes in grayscale mode and holds the packed result. Depends on ncf_pkg.
`default_nettype none

module ncf_merge import ncf_pkg::*; #(
   parameter int PLANES = NCF_PLANES
) (
   input  wire logic                               clock,
   input  wire logic                               advance,
   input  wire logic                               four_planes,
   input  wire logic [PLANES-1:0][SCALED_W-1:0]    lane_scaled,
   output logic      [WORD_W-1:0]                  pixel
);

   // Zero when not positive, else the integer part saturated to 255
   function automatic logic [PIX_W-1:0] clamp_byte(input logic [SCALED_W-1:0] v);
      logic [PIX_W-1:0] res;
      if (v[SCALED_W-1] || (v == '0)) begin
         res = '0;
      end else if (|v[SCALED_W-2:FRAC_W+PIX_W]) begin
         res = '1;
      end else begin
         res = v[FRAC_W +: PIX_W];
      end
      return res;
   endfunction

   logic [WORD_W-1:0] pixel_ff;
   logic [WORD_W-1:0] pixel_in;

   for (genvar p = 0; p < NCF_MAX_PLANES; p++) begin : g_byte
      if (p == 0) begin : g_first
         assign pixel_in[p*PIX_W +: PIX_W] = clamp_byte(lane_scaled[p]);
      end else if (p < PLANES) begin : g_upper
         assign pixel_in[p*PIX_W +: PIX_W] =
            four_planes ? clamp_byte(lane_scaled[p]) : '0;
      end else begin : g_absent
         assign pixel_in[p*PIX_W +: PIX_W] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

`default_nettype wire

// File: rtl/normalized_conv3x3_filter.sv
// Top level of the normalized 3x3 convolution filter: registers, lanes,
// merge and beat control. Depends on ncf_pkg, ncf_if, ncf_lane, ncf_merge.
//
// Usage:
//   req_chan carries one 3x3 window per beat; every pixel packs four byte
//   planes, plane 0 in the low byte. rsp_chan returns one filtered pixel per
//   window, in order. csr_chan writes the kernel rows (signed Q8.8), the
//   Q16.16 normalization factor and the grayscale/RGBA mode; write it only
//   while no window is in flight. csr_chan is always ready.
//   Pipeline: a window accepted at req_chan has its products registered at
//   the accepting edge, then row sums, total, scaling and the clamped output
//   register in turn before its result shows at rsp_chan with valid high.
//   Throughput: one window per clock while rsp_chan does not stall; each
//   plane has its own lane, so all planes are worked on in the same cycle
//   and the pipeline is fully pipelined end to end.
//   Stall: the pipeline advances as one; while a result waits at rsp_chan
//   and the receiver holds ready low, every stage holds and req_chan.ready
//   drops. An empty output register lets the pipeline move; bubbles in earlier stages do not.
//   Reset: clears all in-flight beats and loads the identity kernel
//   (center 1.0), factor 1.0 and grayscale mode.
`default_nettype none

module normalized_conv3x3_filter import ncf_pkg::*; #(
   parameter int PLANES = NCF_PLANES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ncf_req_if.sink    req_chan,
   ncf_rsp_if.source  rsp_chan,
   ncf_csr_if.sink    csr_chan
);

   // Configuration registers
   logic [ROW_COEF_W-1:0] coef_top_ff, coef_top_in;
   logic [ROW_COEF_W-1:0] coef_mid_ff, coef_mid_in;
   logic [ROW_COEF_W-1:0] coef_bot_ff, coef_bot_in;
   scale_type             scale_ff, scale_in;
   logic                  four_planes_ff, four_planes_in;

   // One valid bit per pipeline stage, the last one is the output register
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic                  advance;

   window_type                       window;
   kernel_type                       kernel;
   logic [PLANES-1:0][SCALED_W-1:0]  lane_scaled;

   assign csr_chan.ready = 1'b1;

   // Decode register writes; drop writes to unknown indexes
   always_comb begin
      coef_top_in    = coef_top_ff;
      coef_mid_in    = coef_mid_ff;
      coef_bot_in    = coef_bot_ff;
      scale_in       = scale_ff;
      four_planes_in = four_planes_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_COEF_TOP:    coef_top_in    = csr_chan.data;
            CSR_COEF_MIDDLE: coef_mid_in    = csr_chan.data;
            CSR_COEF_BOTTOM: coef_bot_in    = csr_chan.data;
            CSR_NORM_SCALE:  scale_in       = csr_chan.data[SCALE_W-1:0];
            CSR_FOUR_PLANES: four_planes_in = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff    <= COEF_TOP_RESET;
         coef_mid_ff    <= COEF_MIDDLE_RESET;
         coef_bot_ff    <= COEF_BOTTOM_RESET;
         scale_ff       <= NORM_SCALE_RESET;
         four_planes_ff <= 1'b0;
      end else begin
         coef_top_ff    <= coef_top_in;
         coef_mid_ff    <= coef_mid_in;
         coef_bot_ff    <= coef_bot_in;
         scale_ff       <= scale_in;
         four_planes_ff <= four_planes_in;
      end
   end

   // Advance whenever the output slot is empty or being drained
   assign advance        = !valid_ff[PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign valid_in       = advance ? {valid_ff[PIPE_DEPTH-2:0], req_chan.valid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Taps in row-major order, tap 0 top left
   assign window = {req_chan.win_bottom_right, req_chan.win_bottom_mid,
                    req_chan.win_bottom_left,  req_chan.win_mid_right,
                    req_chan.win_center,       req_chan.win_mid_left,
                    req_chan.win_top_right,    req_chan.win_top_mid,
                    req_chan.win_top_left};
   assign kernel = {coef_bot_ff, coef_mid_ff, coef_top_ff};

   // One lane per plane
   for (genvar p = 0; p < PLANES; p++) begin : g_lane
      pix_win_type plane_pix;

      always_comb begin
         for (int i = 0; i < TAPS; i++) begin
            plane_pix[i] = window[i][p*PIX_W +: PIX_W];
         end
      end

      ncf_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .pix     (plane_pix),
         .kernel  (kernel),
         .scale   (scale_ff),
         .scaled  (lane_scaled[p])
      );
   end

   ncf_merge #(
      .PLANES (PLANES)
   ) u_merge (
      .clock       (clock),
      .advance     (advance),
      .four_planes (four_planes_ff),
      .lane_scaled (lane_scaled),
      .pixel       (rsp_chan.filtered_pixel)
   );

   assign rsp_chan.valid = valid_ff[PIPE_DEPTH-1];

endmodule

`default_nettype wire
